// ===== hw/rtl/ppt_pkg.sv =====
// Package for the phase pulse trigger: channel payload types and the
// control bundle passed from the top level to the trigger lanes.
// No dependencies.
`timescale 1ns / 1ps

package ppt_pkg;

  // Sample beat or table write.
  typedef struct packed {
    logic               cmd;
    logic [8:0]         group;
    logic signed [15:0] phase_0;
    logic signed [15:0] phase_1;
    logic signed [15:0] phase_2;
    logic signed [15:0] phase_3;
    logic [35:0]        stamp;
    logic               beat_end;
    logic [1:0]         lane_select;
    logic signed [7:0]  threshold_value;
    logic [7:0]         holdoff_value;
  } in_t;

  // Trigger record or photon.
  typedef struct packed {
    logic               kind;
    logic [8:0]         record_group;
    logic [3:0]         trigger_mask;
    logic               record_end;
    logic [10:0]        channel;
    logic signed [15:0] photon_phase;
    logic [35:0]        photon_time;
    logic               run_end;
  } out_t;

  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_WRITE  = 1'b1;

  localparam logic KIND_RECORD = 1'b0;
  localparam logic KIND_PHOTON = 1'b1;

  // Lane control, one set for all lanes.
  typedef struct packed {
    logic       acc;   // beat transfer, read row
    logic       adv;   // stage 1 retires, write row
    logic       clr;   // clearing pass
    logic       cmd;   // stage 1 holds a table write
    logic [2:0] sel;   // lane addressed by the write
  } ctl_t;

endpackage

// ===== hw/rtl/ppt_stream_if.sv =====
// Valid/ready stream channel carrying one payload of type T.
// Depends on nothing; payload types come from ppt_pkg at instantiation.
`timescale 1ns / 1ps

interface ppt_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/ppt_lane.sv =====
// One trigger lane: per-group state memory, bypass of the last write and
// the threshold / holdoff / peak tracking update. Uses ppt_pkg::ctl_t.
`timescale 1ns / 1ps

module ppt_lane #(
  parameter int LANE         = 0,
  parameter int GROUPS       = 512,
  parameter int SAMPLE_BITS  = 16,
  parameter int HOLDOFF_BITS = 8,
  parameter int TIME_BITS    = 36,
  localparam int AW          = $clog2(GROUPS)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  ppt_pkg::ctl_t                 ctl,
  input  logic [AW-1:0]                 rd_addr,
  input  logic [AW-1:0]                 wr_addr,
  input  logic signed [SAMPLE_BITS-1:0] phase,
  input  logic [TIME_BITS-1:0]          stamp,
  input  logic signed [7:0]             thr_value,
  input  logic [HOLDOFF_BITS-1:0]       hold_value,
  output logic                          fire,
  output logic                          emit,
  output logic signed [SAMPLE_BITS-1:0] best_out,
  output logic [TIME_BITS-1:0]          ptime
);

  logic [HOLDOFF_BITS-1:0]       cnt_mem  [GROUPS];
  logic signed [SAMPLE_BITS-1:0] bp_mem   [GROUPS];
  logic [HOLDOFF_BITS-1:0]       br_mem   [GROUPS];
  logic signed [7:0]             thr_mem  [GROUPS];
  logic [HOLDOFF_BITS-1:0]       hold_mem [GROUPS];

  logic [HOLDOFF_BITS-1:0]       rd_cnt, rd_br, rd_hold;
  logic signed [SAMPLE_BITS-1:0] rd_bp;
  logic signed [7:0]             rd_thr;

  logic                          lst_vld;
  logic [AW-1:0]                 lst_addr;
  logic [HOLDOFF_BITS-1:0]       lst_cnt, lst_br, lst_hold;
  logic signed [SAMPLE_BITS-1:0] lst_bp;
  logic signed [7:0]             lst_thr;

  logic [HOLDOFF_BITS-1:0]       cur_cnt, cur_br, cur_hold;
  logic signed [SAMPLE_BITS-1:0] cur_bp;
  logic signed [7:0]             cur_thr;
  logic signed [SAMPLE_BITS-1:0] thr_ext, thr_s;

  logic [HOLDOFF_BITS-1:0]       cnt_next, br_next, hold_next;
  logic signed [SAMPLE_BITS-1:0] bp_next;
  logic signed [7:0]             thr_next;
  logic                          we;

  assign we = ctl.adv || ctl.clr;

  always_ff @(posedge clk) begin
    if (ctl.acc) begin
      rd_cnt  <= cnt_mem[rd_addr];
      rd_bp   <= bp_mem[rd_addr];
      rd_br   <= br_mem[rd_addr];
      rd_thr  <= thr_mem[rd_addr];
      rd_hold <= hold_mem[rd_addr];
    end
    if (we) begin
      cnt_mem[wr_addr]  <= ctl.clr ? '0 : cnt_next;
      bp_mem[wr_addr]   <= ctl.clr ? '0 : bp_next;
      br_mem[wr_addr]   <= ctl.clr ? '0 : br_next;
      thr_mem[wr_addr]  <= ctl.clr ? '0 : thr_next;
      hold_mem[wr_addr] <= ctl.clr ? '0 : hold_next;
    end
  end

  // The read issued with a transfer misses the write retiring on the same edge.
  always_ff @(posedge clk) begin
    if (rst) begin
      lst_vld <= 1'b0;
    end else if (ctl.adv) begin
      lst_vld <= 1'b1;
    end
    if (ctl.adv) begin
      lst_addr <= wr_addr;
      lst_cnt  <= cnt_next;
      lst_bp   <= bp_next;
      lst_br   <= br_next;
      lst_thr  <= thr_next;
      lst_hold <= hold_next;
    end
  end

  always_comb begin
    if (lst_vld && lst_addr == wr_addr) begin
      cur_cnt  = lst_cnt;
      cur_bp   = lst_bp;
      cur_br   = lst_br;
      cur_thr  = lst_thr;
      cur_hold = lst_hold;
    end else begin
      cur_cnt  = rd_cnt;
      cur_bp   = rd_bp;
      cur_br   = rd_br;
      cur_thr  = rd_thr;
      cur_hold = rd_hold;
    end
    thr_ext = SAMPLE_BITS'(cur_thr);
    thr_s   = thr_ext <<< (SAMPLE_BITS - 8);

    cnt_next  = cur_cnt;
    bp_next   = cur_bp;
    br_next   = cur_br;
    thr_next  = cur_thr;
    hold_next = cur_hold;
    fire      = 1'b0;
    emit      = 1'b0;
    if (ctl.cmd) begin
      if (ctl.sel == 3'(LANE)) begin
        thr_next  = thr_value;
        hold_next = hold_value;
      end
    end else if (phase < thr_s && cur_cnt == '0) begin
      fire     = 1'b1;
      cnt_next = cur_hold;
      bp_next  = phase;
      br_next  = cur_hold;
    end else if (cur_cnt != '0) begin
      cnt_next = cur_cnt - 1'b1;
      if (cur_bp > phase) begin
        bp_next = phase;
        br_next = cnt_next;
      end
      emit = (cur_cnt == HOLDOFF_BITS'(1));
    end
    best_out = bp_next;
    ptime    = stamp - TIME_BITS'(br_next);
  end

endmodule

// ===== hw/rtl/ppt_merge.sv =====
// Result merge: holds one beat's record and lane photons and sends them
// out one per transfer, record first, photons in lane order. Uses ppt_pkg.
`timescale 1ns / 1ps

module ppt_merge #(
  parameter int LANES       = 4,
  parameter int GROUPS      = 512,
  parameter int SAMPLE_BITS = 16,
  parameter int TIME_BITS   = 36,
  localparam int AW         = $clog2(GROUPS),
  localparam int LW         = (LANES > 1) ? $clog2(LANES) : 1
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          load,
  output logic                          ready,
  input  logic [AW-1:0]                 grp,
  input  logic                          end_in,
  input  logic [LANES-1:0]              fire,
  input  logic [LANES-1:0]              emit,
  input  logic signed [SAMPLE_BITS-1:0] phase [LANES],
  input  logic [TIME_BITS-1:0]          ptime [LANES],
  ppt_stream_if.source                  out_ch
);
  import ppt_pkg::*;

  logic                          busy, rec_pend;
  logic [LANES-1:0]              pend, rest;
  logic [AW-1:0]                 b_grp;
  logic [LANES-1:0]              b_mask;
  logic                          b_end;
  logic signed [SAMPLE_BITS-1:0] b_ph [LANES];
  logic [TIME_BITS-1:0]          b_t  [LANES];

  logic [LW-1:0] idx;
  logic          last, xfer;
  logic [31:0]   gw, chw;
  logic [7:0]    mw;
  logic [63:0]   tw;
  out_t          o;

  always_comb begin
    idx = '0;
    for (int i = LANES - 1; i >= 0; i--) begin
      if (pend[i]) idx = LW'(i);
    end
    rest = pend & ~(LANES'(1) << idx);
    last = rec_pend ? (pend == '0) : (rest == '0);
  end

  assign xfer  = out_ch.valid && out_ch.ready;
  assign ready = !busy || (xfer && last);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      rec_pend <= 1'b0;
      pend     <= '0;
    end else if (load) begin
      busy     <= 1'b1;
      rec_pend <= 1'b1;
      pend     <= emit;
    end else if (xfer) begin
      if (last) begin
        busy <= 1'b0;
      end else if (rec_pend) begin
        rec_pend <= 1'b0;
      end else begin
        pend <= rest;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      b_grp  <= grp;
      b_mask <= fire;
      b_end  <= end_in;
      b_ph   <= phase;
      b_t    <= ptime;
    end
  end

  always_comb begin
    gw  = 32'(b_grp);
    chw = 32'(b_grp) * 32'(LANES) + 32'(idx);
    mw  = 8'(b_mask);
    tw  = 64'(b_t[idx]);
    o   = '0;
    o.run_end = last;
    if (rec_pend) begin
      o.kind         = KIND_RECORD;
      o.record_group = gw[8:0];
      o.trigger_mask = mw[3:0];
      o.record_end   = b_end;
    end else begin
      o.kind         = KIND_PHOTON;
      o.channel      = chw[10:0];
      o.photon_phase = 16'(b_ph[idx]);
      o.photon_time  = tw[35:0];
    end
  end

  assign out_ch.valid = busy;
  assign out_ch.data  = o;

endmodule

// ===== hw/rtl/phase_pulse_trigger_unit.sv =====
// Phase pulse trigger, top level: input stage, group reduction, trigger
// lanes and result merge. Depends on ppt_pkg, ppt_stream_if, ppt_lane, ppt_merge.
//
// Usage:
//   in_ch  (sink, ppt_pkg::in_t): one transfer per beat. cmd = CMD_SAMPLE
//          carries a group's phases and stamp; cmd = CMD_WRITE loads one
//          channel's threshold and holdoff and gives no result.
//   out_ch (source, ppt_pkg::out_t): each sample beat gives a trigger record
//          then its photons in lane order; run_end marks the last one.
// Path: a beat is registered in stage 1, then in the merge stage, which sends it.
// Throughput: one beat per cycle while the merge stage is free, set by the single
//   read and write port of each lane's state memory (back-to-back beats on one
//   group are bypassed). A beat with k photons holds merge until all are sent.
// Reset: after rst falls the state memories are cleared, one group a cycle,
//   for GROUPS cycles; in_ch.ready stays low meanwhile.
// Stall: when out_ch.ready is low the merge stage holds its results and one
//   more sample beat waits in stage 1; in_ch.ready then drops. Table writes
//   pass stage 1 without waiting on the output.
`timescale 1ns / 1ps

module phase_pulse_trigger_unit #(
  parameter int LANES        = 4,
  parameter int GROUPS       = 512,
  parameter int SAMPLE_BITS  = 16,
  parameter int HOLDOFF_BITS = 8,
  parameter int TIME_BITS    = 36
) (
  input logic        clk,
  input logic        rst,
  ppt_stream_if.sink   in_ch,
  ppt_stream_if.source out_ch
);
  import ppt_pkg::*;

  localparam int AW       = $clog2(GROUPS);
  localparam int RECIP_SH = 18;
  localparam int RECIP    = (2 ** RECIP_SH + GROUPS - 1) / GROUPS;

  logic          clearing;
  logic [AW-1:0] clr_cnt;
  logic          acc, s1_valid, s1_adv, m_ready;
  in_t           s1;
  logic [AW-1:0] s1_grp, in_grp, wr_addr;
  ctl_t          ctl;

  // group mod GROUPS by reciprocal multiply, exact for 9-bit groups
  logic [27:0] prod;
  logic [9:0]  quo;
  logic [21:0] rem;

  logic [63:0]                   sw;
  logic [15:0]                   hw;
  logic [TIME_BITS-1:0]          s1_stamp;
  logic [HOLDOFF_BITS-1:0]       s1_hold;
  logic signed [SAMPLE_BITS-1:0] ph [LANES];
  logic [LANES-1:0]              fire, emit;
  logic signed [SAMPLE_BITS-1:0] best [LANES];
  logic [TIME_BITS-1:0]          ptime [LANES];

  always_comb begin
    prod   = 28'(in_ch.data.group) * 28'(RECIP);
    quo    = prod[27:18];
    rem    = 22'(in_ch.data.group) - 22'(quo) * 22'(GROUPS);
    in_grp = rem[AW-1:0];
  end

  assign s1_adv      = s1_valid && (s1.cmd == CMD_WRITE || m_ready);
  assign in_ch.ready = !clearing && (!s1_valid || s1_adv);
  assign acc         = in_ch.valid && in_ch.ready;
  assign wr_addr     = clearing ? clr_cnt : s1_grp;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_cnt  <= '0;
    end else if (clearing) begin
      if (clr_cnt == AW'(GROUPS - 1)) begin
        clearing <= 1'b0;
        clr_cnt  <= '0;
      end else begin
        clr_cnt <= clr_cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (acc) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
    if (acc) begin
      s1     <= in_ch.data;
      s1_grp <= in_grp;
    end
  end

  always_comb begin
    sw       = 64'(s1.stamp);
    s1_stamp = sw[TIME_BITS-1:0];
    hw       = 16'(s1.holdoff_value);
    s1_hold  = hw[HOLDOFF_BITS-1:0];
    ctl.acc  = acc;
    ctl.adv  = s1_adv;
    ctl.clr  = clearing;
    ctl.cmd  = s1.cmd;
    ctl.sel  = {1'b0, s1.lane_select};
  end

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    if (i == 0) begin : g_p0
      assign ph[i] = s1.phase_0[SAMPLE_BITS-1:0];
    end else if (i == 1) begin : g_p1
      assign ph[i] = s1.phase_1[SAMPLE_BITS-1:0];
    end else if (i == 2) begin : g_p2
      assign ph[i] = s1.phase_2[SAMPLE_BITS-1:0];
    end else if (i == 3) begin : g_p3
      assign ph[i] = s1.phase_3[SAMPLE_BITS-1:0];
    end else begin : g_pz
      assign ph[i] = '0;
    end

    ppt_lane #(
      .LANE        (i),
      .GROUPS      (GROUPS),
      .SAMPLE_BITS (SAMPLE_BITS),
      .HOLDOFF_BITS(HOLDOFF_BITS),
      .TIME_BITS   (TIME_BITS)
    ) u_lane (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl),
      .rd_addr   (in_grp),
      .wr_addr   (wr_addr),
      .phase     (ph[i]),
      .stamp     (s1_stamp),
      .thr_value (s1.threshold_value),
      .hold_value(s1_hold),
      .fire      (fire[i]),
      .emit      (emit[i]),
      .best_out  (best[i]),
      .ptime     (ptime[i])
    );
  end

  ppt_merge #(
    .LANES      (LANES),
    .GROUPS     (GROUPS),
    .SAMPLE_BITS(SAMPLE_BITS),
    .TIME_BITS  (TIME_BITS)
  ) u_merge (
    .clk   (clk),
    .rst   (rst),
    .load  (s1_adv && s1.cmd == CMD_SAMPLE),
    .ready (m_ready),
    .grp   (s1_grp),
    .end_in(s1.beat_end),
    .fire  (fire),
    .emit  (emit),
    .phase (best),
    .ptime (ptime),
    .out_ch(out_ch)
  );

`ifndef SYNTHESIS
  a_no_in_while_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !in_ch.ready)
    else $error("input transfer during clearing pass");

  a_stage1_holds: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_adv |=> s1_valid && $stable(s1_grp))
    else $error("stage 1 lost its beat while stalled");

  a_clear_wraps: assert property (@(posedge clk) disable iff (rst)
    $fell(clearing) |-> clr_cnt == '0)
    else $error("clearing pass ended off the last group");

  a_no_out_while_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !out_ch.valid)
    else $error("result during clearing pass");
`endif

endmodule

// ===== tb/sv/phase_pulse_trigger_unit_test.sv =====
// Testbench for phase_pulse_trigger_unit: directed table, then random beats,
// each result checked against an in-bench trigger predictor or a typed-in record.
// Depends on ppt_pkg, ppt_stream_if and the phase_pulse_trigger_unit RTL.
`timescale 1ns / 1ps

module phase_pulse_trigger_unit_test;
  import ppt_pkg::*;

  localparam int N_CHAN      = 2048;
  localparam int N_RANDOM    = 96;
  localparam int STALL_LIMIT = 4000;  // covers the clearing pass and long stalls
  localparam int TAIL_CYCLES = 20;

  typedef struct {
    in_t  beat;
    bit   typed;
    out_t rec;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  ppt_stream_if #(.T(in_t))  in_ch ();
  ppt_stream_if #(.T(out_t)) out_ch ();

  phase_pulse_trigger_unit dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  always #6 clk = ~clk;

  // Trigger state mirror
  logic signed [7:0]  trig_thresh [N_CHAN];
  logic [7:0]         trig_holdoff[N_CHAN];
  logic [7:0]         holdoff_left[N_CHAN];
  logic signed [15:0] peak_phase  [N_CHAN];
  logic [7:0]         peak_left   [N_CHAN];

  out_t expected_results[$];
  int   errors = 0;
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  int   stall_cycles = 0;

  function automatic in_t mk_sample(logic [8:0] g, logic signed [15:0] p0, p1, p2, p3,
                                    logic [35:0] st, logic fe);
    in_t b;
    b = '0;
    b.cmd = CMD_SAMPLE;
    b.group = g;
    b.phase_0 = p0;
    b.phase_1 = p1;
    b.phase_2 = p2;
    b.phase_3 = p3;
    b.stamp = st;
    b.beat_end = fe;
    return b;
  endfunction

  function automatic in_t mk_write(logic [8:0] g, logic [1:0] lane, logic signed [7:0] thr,
                                   logic [7:0] hold);
    in_t b;
    b = '0;
    b.cmd = CMD_WRITE;
    b.group = g;
    b.lane_select = lane;
    b.threshold_value = thr;
    b.holdoff_value = hold;
    return b;
  endfunction

  function automatic out_t mk_record(logic [8:0] g, logic [3:0] m, logic fe);
    out_t r;
    r = '0;
    r.kind = KIND_RECORD;
    r.record_group = g;
    r.trigger_mask = m;
    r.record_end = fe;
    r.run_end = 1'b1;
    return r;
  endfunction

  // Update the mirror for one accepted beat and queue its results.
  function automatic void predict_beat(in_t b);
    logic signed [15:0] ph[4];
    out_t rec;
    out_t photons[$];
    out_t p;
    int ch;
    logic [7:0] nc;
    if (b.cmd == CMD_WRITE) begin
      ch = int'(b.group) * 4 + int'(b.lane_select);
      trig_thresh[ch] = b.threshold_value;
      trig_holdoff[ch] = b.holdoff_value;
      return;
    end
    ph = '{b.phase_0, b.phase_1, b.phase_2, b.phase_3};
    rec = mk_record(b.group, 4'h0, b.beat_end);
    for (int i = 0; i < 4; i++) begin
      ch = int'(b.group) * 4 + i;
      if (int'(ph[i]) < int'(trig_thresh[ch]) * 256 && holdoff_left[ch] == 0) begin
        rec.trigger_mask[i] = 1'b1;
        holdoff_left[ch] = trig_holdoff[ch];
        peak_phase[ch] = ph[i];
        peak_left[ch] = trig_holdoff[ch];
      end else if (holdoff_left[ch] != 0) begin
        nc = holdoff_left[ch] - 8'd1;
        if (peak_phase[ch] > ph[i]) begin
          peak_phase[ch] = ph[i];
          peak_left[ch] = nc;
        end
        if (holdoff_left[ch] == 8'd1) begin
          p = '0;
          p.kind = KIND_PHOTON;
          p.channel = 11'(ch);
          p.photon_phase = peak_phase[ch];
          p.photon_time = b.stamp - 36'(peak_left[ch]);
          photons.push_back(p);
        end
        holdoff_left[ch] = nc;
      end
    end
    if (photons.size() != 0) begin
      rec.run_end = 1'b0;
      photons[photons.size() - 1].run_end = 1'b1;
    end
    expected_results.push_back(rec);
    foreach (photons[k]) expected_results.push_back(photons[k]);
  endfunction

  task automatic send_beat(stim_row_t row);
    int n0;
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= row.beat;
    do @(posedge clk); while (!in_ch.ready);
    n0 = expected_results.size();
    predict_beat(row.beat);
    // typed-in record replaces the predicted one
    if (row.typed) expected_results[n0] = row.rec;
  endtask

  function automatic void check_field(string f, logic [35:0] e, logic [35:0] a);
    if (e !== a) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, f, e, a);
    end
  endfunction

  // Result checker and receiver stalls
  always @(posedge clk) begin
    out_t e;
    out_t a;
    if (!rst && out_ch.valid && out_ch.ready) begin
      a = out_ch.data;
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none actual %h", $time, a);
      end else begin
        e = expected_results.pop_front();
        check_field("kind", e.kind, a.kind);
        check_field("record_group", e.record_group, a.record_group);
        check_field("trigger_mask", e.trigger_mask, a.trigger_mask);
        check_field("record_end", e.record_end, a.record_end);
        check_field("channel", e.channel, a.channel);
        check_field("photon_phase", e.photon_phase, a.photon_phase);
        check_field("photon_time", e.photon_time, a.photon_time);
        check_field("run_end", e.run_end, a.run_end);
      end
    end
    out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles + 1 >= STALL_LIMIT) begin
        $display("phase_pulse_trigger_unit_test NOT OK");
        $finish;
      end
    end
  end

  initial begin
    stim_row_t dir[$];
    stim_row_t row;
    logic [8:0] pool[8];
    int total;
    int r;

    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    foreach (trig_thresh[c]) begin
      trig_thresh[c] = '0;
      trig_holdoff[c] = '0;
      holdoff_left[c] = '0;
      peak_phase[c] = '0;
      peak_left[c] = '0;
    end
    pool = '{9'd0, 9'd3, 9'd100, 9'd170, 9'd255, 9'd256, 9'd341, 9'd511};

    // after reset: zero thresholds, nothing fires on zero phase
    dir.push_back('{mk_sample(9'd0, 0, 0, 0, 0, 36'd0, 1'b0), 1'b1,
                    mk_record(9'd0, 4'h0, 1'b0)});
    // full-scale negative fires every lane; zero holdoff, so no photon
    dir.push_back('{mk_sample(9'd511, -16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768,
                              36'hf_ffff_ffff, 1'b1), 1'b1, mk_record(9'd511, 4'hf, 1'b1)});
    dir.push_back('{mk_sample(9'd511, -16'sd32768, 16'sd32767, -16'sd1, 16'sd0,
                              36'd5, 1'b0), 1'b0, '0});
    dir.push_back('{mk_write(9'd5, 2'd0, 8'sd127, 8'd3), 1'b0, '0});
    dir.push_back('{mk_write(9'd5, 2'd1, -8'sd128, 8'd255), 1'b0, '0});
    dir.push_back('{mk_write(9'd5, 2'd2, 8'sd0, 8'd1), 1'b0, '0});
    dir.push_back('{mk_write(9'd5, 2'd3, -8'sd1, 8'd0), 1'b0, '0});
    dir.push_back('{mk_write(9'd511, 2'd3, 8'sd127, 8'd255), 1'b0, '0});
    dir.push_back('{mk_sample(9'd5, -16'sd100, -16'sd32768, -16'sd1, -16'sd300,
                              36'd1000, 1'b0), 1'b0, '0});
    // new minimum on lane 0, lane 2 expires
    dir.push_back('{mk_sample(9'd5, -16'sd200, 0, -16'sd5, -16'sd300, 36'd1001, 1'b1),
                    1'b0, '0});
    // equal phase keeps the earlier minimum
    dir.push_back('{mk_sample(9'd5, -16'sd200, 0, 0, 0, 36'd1002, 1'b0), 1'b0, '0});
    dir.push_back('{mk_sample(9'd5, 16'sd32767, 0, -16'sd1, 0, 36'd1003, 1'b0), 1'b0, '0});
    // stamp wraps below zero on the expiry
    dir.push_back('{mk_sample(9'd5, 0, 0, 16'sd100, 0, 36'd0, 1'b1), 1'b0, '0});
    dir.push_back('{mk_sample(9'd511, 0, 0, 0, 16'sd1000, 36'd7, 1'b0), 1'b0, '0});

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    total = dir.size() + N_RANDOM;
    for (int n = 0; n < total; n++) begin
      if (n < total / 3) begin
        send_idle_pct = 9;
        recv_idle_pct = 67;
      end else if (n < 2 * total / 3) begin
        send_idle_pct = 67;
        recv_idle_pct = 9;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (n == total / 2) begin
        // hold off until the output side has drained
        in_ch.valid <= 1'b0;
        do @(posedge clk); while (expected_results.size() != 0);
      end
      if (n < dir.size()) begin
        row = dir[n];
      end else begin
        row = '{'0, 1'b0, '0};
        r = $urandom_range(99);
        if (r < 20) begin
          row.beat = mk_write(pool[$urandom_range(7)], 2'($urandom), 8'($urandom),
                              ($urandom_range(4) == 0) ? 8'($urandom) : 8'($urandom_range(6)));
        end else begin
          row.beat = mk_sample((r < 90) ? pool[$urandom_range(7)] : 9'($urandom),
                               16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                               {4'($urandom), 32'($urandom)}, 1'($urandom));
          // in about half the beats all lanes sit near typical thresholds
          if ($urandom_range(1)) begin
            row.beat.phase_0 = 16'($signed($urandom_range(2000)) - 1000);
            row.beat.phase_1 = 16'($signed($urandom_range(8000)) - 4000);
            row.beat.phase_2 = 16'($signed($urandom_range(2000)) - 1000);
            row.beat.phase_3 = 16'($signed($urandom_range(8000)) - 4000);
          end
        end
      end
      send_beat(row);
    end
    in_ch.valid <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("phase_pulse_trigger_unit_test OK");
    end else begin
      $display("phase_pulse_trigger_unit_test NOT OK");
    end
    $finish;
  end

endmodule
